[rtl/sft_pkg.sv]
`timescale 1ns / 1ps

package sft_pkg;

  // Register indexes of the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_ACCEL_GAIN     = 3'd0;
  localparam logic [2:0] REG_ACCEL_DIVISOR  = 3'd1;
  localparam logic [2:0] REG_VELOCITY_GAIN  = 3'd2;
  localparam logic [2:0] REG_VELOCITY_DIV   = 3'd3;
  localparam logic [2:0] REG_STATIC_GAIN    = 3'd4;
  localparam logic [2:0] REG_TORQUE_UPPER   = 3'd5;
  localparam logic [2:0] REG_TORQUE_LOWER   = 3'd6;

  // Input operation codes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;

  // Sequencer commands to one multiply/divide lane
  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
  } lane_ctrl_t;

endpackage

[rtl/sft_lane.sv]
`timescale 1ns / 1ps

// One scaled term: value * gain / divisor, truncated toward zero, low 16 bits.
// Shift-add multiply one multiplier bit per step, then restoring division one
// quotient bit per step, both on magnitudes; sign applied at the output.
module sft_lane (
  input  logic                            clk_i,
  input  sft_pkg::lane_ctrl_t             ctrl_i,
  input  logic [sft_pkg::DATA_W-1:0]      value_i,
  input  logic [sft_pkg::DATA_W-1:0]      gain_i,
  input  logic [sft_pkg::DATA_W-1:0]      divisor_i,
  output logic [sft_pkg::DATA_W-1:0]      quot_o
);

  localparam int unsigned W  = sft_pkg::DATA_W;
  localparam int unsigned PW = sft_pkg::PROD_W;

  logic [PW-1:0] p_q, p_d;
  logic [W-1:0]  r_q, r_d;
  logic [W-1:0]  ma_q, ma_d;
  logic [W-1:0]  dv_q, dv_d;
  logic          neg_q, neg_d;

  logic [W-1:0]  value_mag;
  logic [W-1:0]  gain_mag;
  logic [W:0]    mul_sum;
  logic [W:0]    rem_shift;
  logic          rem_ge;

  assign value_mag = value_i[W-1] ? (~value_i + 1'b1) : value_i;
  assign gain_mag  = gain_i[W-1]  ? (~gain_i + 1'b1)  : gain_i;

  assign mul_sum   = {1'b0, p_q[PW-1:W]} + (p_q[0] ? {1'b0, ma_q} : '0);
  assign rem_shift = {r_q, p_q[PW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, dv_q});

  always_comb begin
    p_d   = p_q;
    r_d   = r_q;
    ma_d  = ma_q;
    dv_d  = dv_q;
    neg_d = neg_q;
    if (ctrl_i.load) begin
      p_d   = {{W{1'b0}}, gain_mag};
      r_d   = '0;
      ma_d  = value_mag;
      dv_d  = (divisor_i == '0) ? {{(W-1){1'b0}}, 1'b1} : divisor_i;
      neg_d = value_i[W-1] ^ gain_i[W-1];
    end else if (ctrl_i.mul_step) begin
      p_d = {mul_sum, p_q[W-1:1]};
    end else if (ctrl_i.div_step) begin
      r_d = rem_ge ? W'(rem_shift - {1'b0, dv_q}) : rem_shift[W-1:0];
      p_d = {p_q[PW-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    r_q   <= r_d;
    ma_q  <= ma_d;
    dv_q  <= dv_d;
    neg_q <= neg_d;
  end

  assign quot_o = neg_q ? (~p_q[W-1:0] + 1'b1) : p_q[W-1:0];

endmodule

[rtl/speed_feedforward_torque_unit.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  op_i, speed_ref_i, torque_ref_in_i
// result    out        out_valid_o/out_ready_i torque_ref_out_o, feedforward_next_o
// config    in         psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// A compute item keeps the block busy: a load step (the transfer), 16 shift-add
// multiply steps and 32 restoring divide steps in the two lanes (run side by
// side), and a finish step that waits for the output register. The result is
// registered at the finish, and the next item can transfer as the result appears.
// A clear item zeroes the stored state and gives no result.
// Reset (rst_ni low, asynchronous) zeroes the stored speed and feedforward and
// loads the register defaults. A stalled result is held in the output register;
// the next item is taken meanwhile, and its finish waits until that register frees.
module speed_feedforward_torque_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] speed_ref_i,
  input  logic [15:0] torque_ref_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] torque_ref_out_o,
  output logic [15:0] feedforward_next_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W = sft_pkg::DATA_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

  // Configuration registers
  logic [W-1:0] accel_gain_q, accel_div_q, vel_gain_q, vel_div_q;
  logic [W-1:0] static_gain_q, upper_q, lower_q;

  // Stored state
  logic [W-1:0] prev_speed_q, prev_speed_d;
  logic [W-1:0] ff_term_q, ff_term_d;

  // Sequencer
  logic [1:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  // Per-item values held across the serial steps
  logic [W-1:0] torque_hold_q, torque_hold_d;
  logic [W-1:0] ff_base_q, ff_base_d;

  // Output register
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] torque_out_q, torque_out_d;
  logic [W-1:0] ff_out_q, ff_out_d;

  logic         cfg_write;
  logic [2:0]   cfg_index;
  logic         in_xfer;
  logic         out_free;

  logic [W-1:0] delta;
  logic [W-1:0] static_term;
  logic signed [W:0] combined;
  logic signed [W:0] upper_ext;
  logic signed [W:0] lower_ext;
  logic [W-1:0] clamped;
  logic [W-1:0] discharge;
  logic [W-1:0] quot_accel, quot_vel;
  logic [W-1:0] ff_next;

  sft_pkg::lane_ctrl_t lane_ctrl;

  // ---------------------------------------------------------------------------
  // Configuration port: writes in the access phase, reads return the register
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q  <= '0;
      accel_div_q   <= 16'd1;
      vel_gain_q    <= '0;
      vel_div_q     <= 16'd1;
      static_gain_q <= '0;
      upper_q       <= 16'h7FFF;
      lower_q       <= 16'h8000;
    end else if (cfg_write) begin
      case (cfg_index)
        sft_pkg::REG_ACCEL_GAIN:    accel_gain_q  <= pwdata[W-1:0];
        sft_pkg::REG_ACCEL_DIVISOR: accel_div_q   <= pwdata[W-1:0];
        sft_pkg::REG_VELOCITY_GAIN: vel_gain_q    <= pwdata[W-1:0];
        sft_pkg::REG_VELOCITY_DIV:  vel_div_q     <= pwdata[W-1:0];
        sft_pkg::REG_STATIC_GAIN:   static_gain_q <= pwdata[W-1:0];
        sft_pkg::REG_TORQUE_UPPER:  upper_q       <= pwdata[W-1:0];
        sft_pkg::REG_TORQUE_LOWER:  lower_q       <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      sft_pkg::REG_ACCEL_GAIN:    prdata = {16'd0, accel_gain_q};
      sft_pkg::REG_ACCEL_DIVISOR: prdata = {16'd0, accel_div_q};
      sft_pkg::REG_VELOCITY_GAIN: prdata = {16'd0, vel_gain_q};
      sft_pkg::REG_VELOCITY_DIV:  prdata = {16'd0, vel_div_q};
      sft_pkg::REG_STATIC_GAIN:   prdata = {16'd0, static_gain_q};
      sft_pkg::REG_TORQUE_UPPER:  prdata = {16'd0, upper_q};
      sft_pkg::REG_TORQUE_LOWER:  prdata = {16'd0, lower_q};
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Load-cycle arithmetic: speed change, static term, clamp and discharge.
  // All of it depends only on the incoming item, the stored speed and feedforward, and the registers.
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign delta = speed_ref_i - prev_speed_q;

  always_comb begin
    if (speed_ref_i == '0) begin
      static_term = '0;
    end else if (speed_ref_i[W-1]) begin
      static_term = ~static_gain_q + 1'b1;
    end else begin
      static_term = static_gain_q;
    end
  end

  assign combined  = $signed({torque_ref_in_i[W-1], torque_ref_in_i})
                   + $signed({ff_term_q[W-1], ff_term_q});
  assign upper_ext = $signed({upper_q[W-1], upper_q});
  assign lower_ext = $signed({lower_q[W-1], lower_q});

  // Upper test first: with crossed limits, values above the upper one take it, all others the lower one
  always_comb begin
    if (combined > upper_ext) begin
      clamped   = upper_q;
      discharge = W'(upper_ext - combined);
    end else if (combined < lower_ext) begin
      clamped   = lower_q;
      discharge = W'(lower_ext - combined);
    end else begin
      clamped   = combined[W-1:0];
      discharge = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: load, multiply steps, divide steps, finish
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    prev_speed_d  = prev_speed_q;
    ff_term_d     = ff_term_q;
    torque_hold_d = torque_hold_q;
    ff_base_d     = ff_base_q;
    lane_ctrl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op_i == sft_pkg::OP_CLEAR) begin
            prev_speed_d = '0;
            ff_term_d    = '0;
          end else begin
            lane_ctrl.load = 1'b1;
            prev_speed_d   = speed_ref_i;
            torque_hold_d  = clamped;
            ff_base_d      = static_term + discharge;
            cnt_d          = '0;
            state_d        = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        lane_ctrl.mul_step = 1'b1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV: begin
        lane_ctrl.div_step = 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        // hold here until the output register can take the result
        if (out_free) begin
          ff_term_d = ff_next;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      prev_speed_q <= '0;
      ff_term_q    <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      prev_speed_q <= prev_speed_d;
      ff_term_q    <= ff_term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    torque_hold_q <= torque_hold_d;
    ff_base_q     <= ff_base_d;
  end

  // ---------------------------------------------------------------------------
  // Scaled terms: acceleration on the speed change, velocity on the speed
  // ---------------------------------------------------------------------------
  sft_lane u_lane_accel (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .value_i   (delta),
    .gain_i    (accel_gain_q),
    .divisor_i (accel_div_q),
    .quot_o    (quot_accel)
  );

  sft_lane u_lane_vel (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .value_i   (speed_ref_i),
    .gain_i    (vel_gain_q),
    .divisor_i (vel_div_q),
    .quot_o    (quot_vel)
  );

  // Sum wraps to 16 bits
  assign ff_next = quot_accel + quot_vel + ff_base_q;

  // ---------------------------------------------------------------------------
  // Output register: drop on transfer, load on finish
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    torque_out_d = torque_out_q;
    ff_out_d     = ff_out_q;
    if ((state_q == ST_FIN) && out_free) begin
      out_valid_d  = 1'b1;
      torque_out_d = torque_hold_q;
      ff_out_d     = ff_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    torque_out_q <= torque_out_d;
    ff_out_q     <= ff_out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign torque_ref_out_o   = torque_out_q;
  assign feedforward_next_o = ff_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_zeroes_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == sft_pkg::OP_CLEAR))
      |=> (ff_term_q == '0) && (prev_speed_q == '0))
    else $error("clear transfer did not zero the stored state");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == sft_pkg::OP_COMPUTE)) |=> !in_ready_o)
    else $error("input taken again right after a compute transfer");

  a_state_matches_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_free) |=> (ff_term_q == feedforward_next_o) && out_valid_o)
    else $error("stored feedforward differs from the reported one");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside the finish step");

endmodule

[test/speed_feedforward_torque_unit_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the speed feedforward torque unit.
// An initial block fills a queue of pending items phase by phase; a clocked
// driver offers them, a clocked monitor predicts each accepted transfer and
// compares every result transfer against the oldest prediction.
module speed_feedforward_torque_unit_test;

  // Write to an index past the last register; the block must ignore it
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic        op;
    logic [15:0] speed;
    logic [15:0] torque;
  } ff_item_t;

  typedef struct packed {
    logic [15:0] torque;
    logic [15:0] ff;
  } torque_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        op              = sft_pkg::OP_COMPUTE;
  logic [15:0] speed_ref       = '0;
  logic [15:0] torque_ref_in   = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [15:0] torque_ref_out;
  logic [15:0] feedforward_next;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [4:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  speed_feedforward_torque_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .op_i               (op),
    .speed_ref_i        (speed_ref),
    .torque_ref_in_i    (torque_ref_in),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .torque_ref_out_o   (torque_ref_out),
    .feedforward_next_o (feedforward_next),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the register file, loaded with the reset defaults
  logic [15:0] cfg_ka     = 16'h0000;
  logic [15:0] cfg_ka_div = 16'h0001;
  logic [15:0] cfg_kv     = 16'h0000;
  logic [15:0] cfg_kv_div = 16'h0001;
  logic [15:0] cfg_ks     = 16'h0000;
  logic [15:0] cfg_upper  = 16'h7FFF;
  logic [15:0] cfg_lower  = 16'h8000;

  // Shadow copy of the stored speed and feedforward term
  logic [15:0] prev_speed = '0;
  logic [15:0] ff_term    = '0;

  ff_item_t       pending_items[$];
  torque_result_t expected_torque[$];
  int             errors         = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  bit             hold_go        = 1'b0;
  logic           long_hold      = 1'b0;

  // gain * value / divisor, truncating toward zero; zero divisor acts as one
  function automatic longint scale_by(input longint value, input logic [15:0] gain,
                                      input logic [15:0] div);
    longint g;
    longint d;
    g = $signed(gain);
    if (div == 16'd0) d = 1;
    else d = div;
    return (value * g) / d;
  endfunction

  // Work out the result of one compute transfer and advance the shadow state
  function automatic void predict_feedforward(input logic [15:0] spd, input logic [15:0] tq,
                                              output torque_result_t res);
    logic [15:0] delta16;
    longint      speed;
    longint      delta;
    longint      sgn;
    longint      ks;
    longint      ff;
    longint      combined;
    longint      stored;
    longint      upper;
    longint      lower;
    longint      discharge;
    speed    = $signed(spd);
    delta16  = spd - prev_speed;
    delta    = $signed(delta16);
    sgn      = (speed > 0) ? 1 : ((speed < 0) ? -1 : 0);
    ks       = $signed(cfg_ks);
    prev_speed = spd;

    ff = scale_by(delta, cfg_ka, cfg_ka_div) + scale_by(speed, cfg_kv, cfg_kv_div) + sgn * ks;

    combined  = $signed(tq);
    stored    = $signed(ff_term);
    combined  = combined + stored;
    upper     = $signed(cfg_upper);
    lower     = $signed(cfg_lower);
    discharge = 0;
    // Upper test first, so crossed limits resolve to the upper one on overshoot
    if (combined > upper) begin
      discharge = upper - combined;
      combined  = upper;
    end else if (combined < lower) begin
      discharge = lower - combined;
      combined  = lower;
    end

    ff_term    = 16'(ff + discharge);
    res.torque = 16'(combined);
    res.ff     = ff_term;
  endfunction

  // Driver: offer the next pending item once the current transfer is done
  always @(posedge clk_i) begin
    if (!in_valid || in_ready) begin
      if (rst_n && pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        op            <= pending_items[0].op;
        speed_ref     <= pending_items[0].speed;
        torque_ref_in <= pending_items[0].torque;
        pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, and hold off completely during the long hold
  always @(posedge clk_i) begin
    out_ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off: fill the block up and let it stall its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Monitor: predict on input transfers, check on result transfers
  always @(posedge clk_i) begin : result_check
    torque_result_t want;
    if (in_valid && in_ready) begin
      if (op == sft_pkg::OP_CLEAR) begin
        prev_speed = '0;
        ff_term    = '0;
      end else begin
        predict_feedforward(speed_ref, torque_ref_in, want);
        expected_torque.push_back(want);
      end
    end
    if (out_valid && out_ready) begin
      if (expected_torque.size() == 0) begin
        $error("result transfer with nothing expected: torque_ref_out %0d feedforward_next %0d",
               $signed(torque_ref_out), $signed(feedforward_next));
        errors++;
      end else begin
        want = expected_torque.pop_front();
        if (torque_ref_out !== want.torque) begin
          $error("torque_ref_out expected %0d actual %0d",
                 $signed(want.torque), $signed(torque_ref_out));
          errors++;
        end
        if (feedforward_next !== want.ff) begin
          $error("feedforward_next expected %0d actual %0d",
                 $signed(want.ff), $signed(feedforward_next));
          errors++;
        end
      end
    end
  end

  // Register write in a setup and an access phase; update the shadow register file on completion
  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sft_pkg::REG_ACCEL_GAIN:    cfg_ka     = value;
      sft_pkg::REG_ACCEL_DIVISOR: cfg_ka_div = value;
      sft_pkg::REG_VELOCITY_GAIN: cfg_kv     = value;
      sft_pkg::REG_VELOCITY_DIV:  cfg_kv_div = value;
      sft_pkg::REG_STATIC_GAIN:   cfg_ks     = value;
      sft_pkg::REG_TORQUE_UPPER:  cfg_upper  = value;
      sft_pkg::REG_TORQUE_LOWER:  cfg_lower  = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] ka, input logic [15:0] ka_div,
                           input logic [15:0] kv, input logic [15:0] kv_div,
                           input logic [15:0] ks, input logic [15:0] upper,
                           input logic [15:0] lower);
    write_register(sft_pkg::REG_ACCEL_GAIN, ka);
    write_register(sft_pkg::REG_ACCEL_DIVISOR, ka_div);
    write_register(sft_pkg::REG_VELOCITY_GAIN, kv);
    write_register(sft_pkg::REG_VELOCITY_DIV, kv_div);
    write_register(sft_pkg::REG_STATIC_GAIN, ks);
    write_register(sft_pkg::REG_TORQUE_UPPER, upper);
    write_register(sft_pkg::REG_TORQUE_LOWER, lower);
  endtask

  // Wait until every item is through, then let a clear or a tail finish
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_torque.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add_item(input logic item_op, input logic [15:0] spd, input logic [15:0] tq);
    ff_item_t it;
    it.op     = item_op;
    it.speed  = spd;
    it.torque = tq;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_divisor();
    case ($urandom_range(6))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic pick_random_setting();
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] upper;
    logic [15:0] lower;
    a = 16'($urandom());
    b = 16'($urandom());
    case ($urandom_range(4))
      0: begin
        upper = 16'h7FFF;
        lower = 16'h8000;
      end
      1: begin
        // crossed: lower above upper
        upper = ($signed(a) < $signed(b)) ? a : b;
        lower = ($signed(a) < $signed(b)) ? b : a;
      end
      2: begin
        upper = 16'($urandom_range(0, 3000));
        lower = -upper;
      end
      default: begin
        upper = ($signed(a) < $signed(b)) ? b : a;
        lower = ($signed(a) < $signed(b)) ? a : b;
      end
    endcase
    write_all(pick_gain(), pick_divisor(), pick_gain(), pick_divisor(), pick_gain(),
              upper, lower);
  endtask

  // Mostly smooth speed profiles, with jumps, extremes and the odd clear
  function automatic ff_item_t next_random_item(inout logic [15:0] track);
    ff_item_t it;
    it.op = ($urandom_range(99) < 8) ? sft_pkg::OP_CLEAR : sft_pkg::OP_COMPUTE;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: track = track + 16'($urandom_range(0, 400)) - 16'd200;
      5:             track = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      6:             track = 16'($urandom_range(0, 2)) - 16'd1;
      default:       track = 16'($urandom());
    endcase
    it.speed  = track;
    it.torque = ($urandom_range(99) < 60) ? 16'($urandom())
                                          : 16'($urandom_range(0, 4000)) - 16'd2000;
    return it;
  endfunction

  initial begin : stimulus
    logic [15:0] track;
    track = '0;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: zero gains, full-range limits
    @(negedge clk_i);
    add_item(sft_pkg::OP_COMPUTE, 16'h7FFF, 16'h7FFF);
    add_item(sft_pkg::OP_COMPUTE, 16'h8000, 16'h8000);
    add_item(sft_pkg::OP_CLEAR,   16'h1234, 16'h4321);
    add_item(sft_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    drain();

    // Extreme gains, zero accel divisor, narrow limits, delta wrap
    write_all(16'h7FFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'd1000, 16'hFC18);
    @(negedge clk_i);
    add_item(sft_pkg::OP_COMPUTE, 16'h7FFF, 16'h0000);
    add_item(sft_pkg::OP_COMPUTE, 16'h8000, 16'h7FFF);
    add_item(sft_pkg::OP_COMPUTE, 16'h0000, 16'h8000);
    add_item(sft_pkg::OP_COMPUTE, 16'hFFFF, 16'h0000);
    add_item(sft_pkg::OP_COMPUTE, 16'h0001, 16'h0000);
    add_item(sft_pkg::OP_CLEAR,   16'hFFFF, 16'hFFFF);
    add_item(sft_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    drain();

    // Crossed limits, zero velocity divisor, and an ignored write past the map
    write_all(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h8000, 16'hFF9C, 16'h0064);
    write_register(REG_UNMAPPED, 16'h5A5A);
    @(negedge clk_i);
    add_item(sft_pkg::OP_COMPUTE, 16'h0100, 16'h7FFF);
    add_item(sft_pkg::OP_COMPUTE, 16'h8000, 16'h8000);
    add_item(sft_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
    add_item(sft_pkg::OP_COMPUTE, 16'h7FFF, 16'h0032);
    add_item(sft_pkg::OP_COMPUTE, 16'hFF00, 16'hFFCE);
    drain();

    // Random settings, cycling through the idling modes
    for (int phase = 0; phase < 8; phase++) begin
      pick_random_setting();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      @(negedge clk_i);
      for (int n = 0; n < 100; n++) pending_items.push_back(next_random_item(track));
      drain();
    end

    // Back-pressure: keep offering while the receiver holds off
    pick_random_setting();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    for (int n = 0; n < 40; n++) pending_items.push_back(next_random_item(track));
    hold_go = 1'b1;
    drain();

    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_torque.size() == 0) begin
      $display("speed_feedforward_torque_unit: match");
    end else begin
      $display("speed_feedforward_torque_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #10_000_000;
    $display("speed_feedforward_torque_unit: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/sft_pkg.sv
rtl/sft_lane.sv
rtl/speed_feedforward_torque_unit.sv
test/speed_feedforward_torque_unit_test.sv
